FILE: sv/rbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_pkg: shared types and constants of the rectangle bisection partitioner
// Field widths, status codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package rbp_pkg;

	localparam int unsigned MAX_PARTS_DEF = 16;
	localparam int unsigned DIM_BITS_DEF  = 16;

	localparam int unsigned COORD_W  = 16;
	localparam int unsigned PARTS_W  = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned INDEX_W  = 4;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK           = 2'd0,
		STATUS_INVALID      = 2'd1,
		STATUS_NOT_POSSIBLE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_INIT,
		MEM_KEPT,
		MEM_FRESH,
		MEM_READ
	} mem_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK1,
		ST_CHK2,
		ST_ERR,
		ST_SCAN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_SPLIT_KEPT,
		ST_SPLIT_FRESH,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	typedef struct packed {
		mem_op_t mem_op;
		logic    scan_vld;
		logic    mul_req;
		logic    best_clr;
		logic    load_out;
		status_t out_status;
		logic    out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic invalid;
		logic not_possible;
	} dp_sts_t;

endpackage

FILE: sv/rbp_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp channels: request and result handshake interfaces
// Valid/ready channels carrying the partition request and one rectangle.
// ----------------------------------------------------------------------------
interface rbp_req_if;
	import rbp_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] row_count;
	logic [COORD_W-1:0] col_count;
	logic [PARTS_W-1:0] part_count;

	modport source (output valid, row_count, col_count, part_count, input ready);
	modport sink   (input valid, row_count, col_count, part_count, output ready);
endinterface

interface rbp_rsp_if;
	import rbp_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  rect_index;
	logic [COORD_W-1:0]  row_begin;
	logic [COORD_W-1:0]  row_end;
	logic [COORD_W-1:0]  col_begin;
	logic [COORD_W-1:0]  col_end;
	logic                last_rect;

	modport source (output valid, status, rect_index, row_begin, row_end, col_begin,
		col_end, last_rect, input ready);
	modport sink   (input valid, status, rect_index, row_begin, row_end, col_begin,
		col_end, last_rect, output ready);
endinterface

FILE: sv/rect_bisection_partitioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_bisection_partitioner: largest-first recursive 2D bisection
// Splits a rows x cols grid into part_count rectangles and returns them in
// list order, or a single error result.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------------
//  req     | in  | valid/ready | row_count, col_count, part_count
//  rsp     | out | valid/ready | status, rect_index, row/col begin/end, last_rect
//
//  Sequence: one request at a time. The check runs through CHK1 and CHK2;
//  with c rectangles held, each split makes c memory reads through the area
//  pipeline, passes DRAIN1 and DRAIN2, then makes 2 writes on the single
//  memory port; each result is a memory read and a result register load.
//  Reset: arst_n clears the sequencer and the result valid; the rectangle
//  memory is never cleared, every entry is written before it is read.
//  Stalls: a held result only blocks the next result; after the last result
//  is loaded into the result register the next request is taken at once.
//
module rect_bisection_partitioner #(
	parameter int unsigned MAX_PARTS = rbp_pkg::MAX_PARTS_DEF,
	parameter int unsigned DIM_BITS  = rbp_pkg::DIM_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rbp_req_if.sink   req,
	rbp_rsp_if.source rsp
);
	import rbp_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_PARTS);
	localparam int unsigned CNT_W = $clog2(MAX_PARTS + 1);

	// sequencer to datapath
	dp_cmd_t           cmd;
	logic [IDX_W-1:0]  addr;
	logic              ld_req;
	// datapath to sequencer
	dp_sts_t           sts;
	logic [CNT_W-1:0]  parts;

	rbp_ctrl #(
		.MAX_PARTS (MAX_PARTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ld_req    (ld_req),
		.cmd       (cmd),
		.addr      (addr),
		.sts       (sts),
		.parts     (parts)
	);

	// area products, best-rectangle tracking and the result register
	rbp_datapath #(
		.MAX_PARTS (MAX_PARTS),
		.DIM_BITS  (DIM_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld_req     (ld_req),
		.row_count  (req.row_count),
		.col_count  (req.col_count),
		.part_count (req.part_count),
		.cmd        (cmd),
		.addr       (addr),
		.sts        (sts),
		.parts      (parts),
		.status     (rsp.status),
		.rect_index (rsp.rect_index),
		.row_begin  (rsp.row_begin),
		.row_end    (rsp.row_end),
		.col_begin  (rsp.col_begin),
		.col_end    (rsp.col_end),
		.last_rect  (rsp.last_rect)
	);

endmodule

FILE: sv/rbp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_datapath: rectangle store, area scan pipeline and split arithmetic
// Holds the request, the rectangle memory, the best-area tracker and the
// result register.
// ----------------------------------------------------------------------------
module rbp_datapath #(
	parameter int unsigned MAX_PARTS = rbp_pkg::MAX_PARTS_DEF,
	parameter int unsigned DIM_BITS  = rbp_pkg::DIM_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               ld_req,
	input  logic [rbp_pkg::COORD_W-1:0]        row_count,
	input  logic [rbp_pkg::COORD_W-1:0]        col_count,
	input  logic [rbp_pkg::PARTS_W-1:0]        part_count,
	input  rbp_pkg::dp_cmd_t                   cmd,
	input  logic [$clog2(MAX_PARTS)-1:0]       addr,
	output rbp_pkg::dp_sts_t                   sts,
	output logic [$clog2(MAX_PARTS+1)-1:0]     parts,
	output logic [rbp_pkg::STATUS_W-1:0]       status,
	output logic [rbp_pkg::INDEX_W-1:0]        rect_index,
	output logic [rbp_pkg::COORD_W-1:0]        row_begin,
	output logic [rbp_pkg::COORD_W-1:0]        row_end,
	output logic [rbp_pkg::COORD_W-1:0]        col_begin,
	output logic [rbp_pkg::COORD_W-1:0]        col_end,
	output logic                               last_rect
);
	import rbp_pkg::*;

	localparam int unsigned IDX_W  = $clog2(MAX_PARTS);
	localparam int unsigned CNT_W  = $clog2(MAX_PARTS + 1);
	localparam int unsigned AREA_W = 2 * DIM_BITS;

	typedef struct packed {
		logic [DIM_BITS-1:0] top;
		logic [DIM_BITS-1:0] bottom;
		logic [DIM_BITS-1:0] left;
		logic [DIM_BITS-1:0] right;
	} rect_t;

	logic [COORD_W-1:0] row_q, col_q;
	logic [PARTS_W-1:0] part_q;

	rect_t              rect_mem_q [MAX_PARTS];
	rect_t              rd_s1, rect_s2, best_q;
	logic               v_s1, v_s2;
	logic [IDX_W-1:0]   idx_s1, idx_s2, best_idx_q;
	logic [AREA_W-1:0]  area_s2, max_area_q;

	logic [DIM_BITS-1:0] mul_a, mul_b;
	logic [DIM_BITS-1:0] h, w, mid_r, mid_c;
	logic                cut_rows;
	rect_t               init_rect, kept_rect, fresh_rect;

	// request capture
	always_ff @(posedge clk) begin
		if (ld_req) begin
			row_q  <= row_count;
			col_q  <= col_count;
			part_q <= part_count;
		end
	end

	// shared multiplier: grid cell count during the check, areas during a scan
	always_comb begin
		if (cmd.mul_req) begin
			mul_a = DIM_BITS'(row_q);
			mul_b = DIM_BITS'(col_q);
		end else begin
			mul_a = rd_s1.bottom - rd_s1.top;
			mul_b = rd_s1.right - rd_s1.left;
		end
	end

	always_ff @(posedge clk) begin
		area_s2 <= AREA_W'(mul_a) * AREA_W'(mul_b);
		rect_s2 <= rd_s1;
		idx_s2  <= idx_s1;
		if (cmd.mem_op == MEM_READ) begin
			idx_s1 <= addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_vld;
			v_s2 <= v_s1;
		end
	end

	// first strictly larger area wins, so ties keep the lowest index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_area_q <= '0;
		end else if (cmd.best_clr) begin
			max_area_q <= '0;
		end else if (v_s2 && area_s2 > max_area_q && area_s2 > AREA_W'(1)) begin
			max_area_q <= area_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.best_clr && v_s2 && area_s2 > max_area_q && area_s2 > AREA_W'(1)) begin
			best_q     <= rect_s2;
			best_idx_q <= idx_s2;
		end
	end

	// halving of the chosen rectangle
	always_comb begin
		h        = best_q.bottom - best_q.top;
		w        = best_q.right - best_q.left;
		cut_rows = (h >= w && h > DIM_BITS'(1)) || w == DIM_BITS'(1);
		mid_r    = best_q.top + (h >> 1);
		mid_c    = best_q.left + (w >> 1);

		kept_rect  = best_q;
		fresh_rect = best_q;
		if (cut_rows) begin
			kept_rect.bottom = mid_r;
			fresh_rect.top   = mid_r;
		end else begin
			kept_rect.right  = mid_c;
			fresh_rect.left  = mid_c;
		end

		init_rect.top    = '0;
		init_rect.bottom = DIM_BITS'(row_q);
		init_rect.left   = '0;
		init_rect.right  = DIM_BITS'(col_q);
	end

	// rectangle memory, one access per cycle
	always_ff @(posedge clk) begin
		case (cmd.mem_op)
			MEM_INIT:  rect_mem_q[addr]       <= init_rect;
			MEM_KEPT:  rect_mem_q[best_idx_q] <= kept_rect;
			MEM_FRESH: rect_mem_q[addr]       <= fresh_rect;
			MEM_READ:  rd_s1                  <= rect_mem_q[addr];
			default: begin
			end
		endcase
	end

	// request checks
	always_comb begin
		sts.invalid = row_q == '0 || col_q == '0 || part_q == '0 ||
			(32'(row_q) >> DIM_BITS) != 32'd0 || (32'(col_q) >> DIM_BITS) != 32'd0 ||
			32'(part_q) > MAX_PARTS;
		sts.not_possible = AREA_W'(part_q) > area_s2;
	end

	assign parts = CNT_W'(part_q);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status    <= cmd.out_status;
			last_rect <= cmd.out_last;
			if (cmd.out_status == STATUS_OK) begin
				rect_index <= INDEX_W'(32'(addr));
				row_begin  <= COORD_W'(32'(rd_s1.top));
				row_end    <= COORD_W'(32'(rd_s1.bottom));
				col_begin  <= COORD_W'(32'(rd_s1.left));
				col_end    <= COORD_W'(32'(rd_s1.right));
			end else begin
				rect_index <= '0;
				row_begin  <= '0;
				row_end    <= '0;
				col_begin  <= '0;
				col_end    <= '0;
			end
		end
	end

endmodule

FILE: sv/rbp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_ctrl: sequencer of the rectangle bisection partitioner
// Steps check, scan, split and emit phases and owns the handshakes.
// ----------------------------------------------------------------------------
module rbp_ctrl #(
	parameter int unsigned MAX_PARTS = rbp_pkg::MAX_PARTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic                           ld_req,
	output rbp_pkg::dp_cmd_t               cmd,
	output logic [$clog2(MAX_PARTS)-1:0]   addr,
	input  rbp_pkg::dp_sts_t               sts,
	input  logic [$clog2(MAX_PARTS+1)-1:0] parts
);
	import rbp_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_PARTS);
	localparam int unsigned CNT_W = $clog2(MAX_PARTS + 1);

	state_t            state_q, state_n;
	logic [IDX_W-1:0]  k_q, k_n;
	logic [CNT_W-1:0]  count_q, count_n;
	logic              rsp_valid_q;
	logic              slot_free, k_last;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign k_last    = (CNT_W'(k_q) + CNT_W'(1)) == count_q;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			k_q     <= k_n;
			count_q <= count_n;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n        = state_q;
		k_n            = k_q;
		count_n        = count_q;
		req_ready      = 1'b0;
		ld_req         = 1'b0;
		addr           = k_q;
		cmd.mem_op     = MEM_NONE;
		cmd.scan_vld   = 1'b0;
		cmd.mul_req    = 1'b0;
		cmd.best_clr   = 1'b0;
		cmd.load_out   = 1'b0;
		cmd.out_status = STATUS_OK;
		cmd.out_last   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ld_req  = 1'b1;
					state_n = ST_CHK1;
				end
			end
			ST_CHK1: begin
				cmd.mul_req = 1'b1;
				state_n     = ST_CHK2;
			end
			ST_CHK2: begin
				if (sts.invalid || sts.not_possible) begin
					state_n = ST_ERR;
				end else begin
					cmd.mem_op   = MEM_INIT;
					addr         = '0;
					cmd.best_clr = 1'b1;
					count_n      = CNT_W'(1);
					k_n          = '0;
					state_n      = (parts == CNT_W'(1)) ? ST_EMIT_RD : ST_SCAN;
				end
			end
			ST_ERR: begin
				addr = '0;
				if (slot_free) begin
					cmd.load_out   = 1'b1;
					cmd.out_status = sts.invalid ? STATUS_INVALID : STATUS_NOT_POSSIBLE;
					cmd.out_last   = 1'b1;
					state_n        = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.mem_op   = MEM_READ;
				cmd.scan_vld = 1'b1;
				if (k_last) begin
					k_n     = '0;
					state_n = ST_DRAIN1;
				end else begin
					k_n = k_q + IDX_W'(1);
				end
			end
			ST_DRAIN1: begin
				state_n = ST_DRAIN2;
			end
			ST_DRAIN2: begin
				state_n = ST_SPLIT_KEPT;
			end
			ST_SPLIT_KEPT: begin
				cmd.mem_op = MEM_KEPT;
				state_n    = ST_SPLIT_FRESH;
			end
			ST_SPLIT_FRESH: begin
				cmd.mem_op   = MEM_FRESH;
				addr         = IDX_W'(count_q);
				cmd.best_clr = 1'b1;
				count_n      = count_q + CNT_W'(1);
				k_n          = '0;
				state_n      = (count_q + CNT_W'(1) == parts) ? ST_EMIT_RD : ST_SCAN;
			end
			ST_EMIT_RD: begin
				cmd.mem_op = MEM_READ;
				state_n    = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (slot_free) begin
					cmd.load_out   = 1'b1;
					cmd.out_status = STATUS_OK;
					cmd.out_last   = k_last;
					if (k_last) begin
						state_n = ST_IDLE;
					end else begin
						k_n     = k_q + IDX_W'(1);
						state_n = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/rbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_checker: port-level checks of the rectangle bisection partitioner
// Bound to the top level; watches the request and result channels.
// ----------------------------------------------------------------------------
module rbp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [rbp_pkg::STATUS_W-1:0]  status,
	input logic [rbp_pkg::INDEX_W-1:0]   rect_index,
	input logic [rbp_pkg::COORD_W-1:0]   row_begin,
	input logic [rbp_pkg::COORD_W-1:0]   row_end,
	input logic [rbp_pkg::COORD_W-1:0]   col_begin,
	input logic [rbp_pkg::COORD_W-1:0]   col_end,
	input logic                          last_rect
);
	import rbp_pkg::*;

	// one request in flight: no second request right after one is taken
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken back to back");

	// an error result is alone and carries no rectangle
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STATUS_OK |-> last_rect && rect_index == '0 &&
		row_begin == '0 && row_end == '0 && col_begin == '0 && col_end == '0)
		else $error("malformed error result");

	// every returned rectangle is non-empty
	a_rect_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STATUS_OK |-> row_end > row_begin && col_end > col_begin)
		else $error("empty rectangle returned");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(rect_index) &&
		$stable(row_begin) && $stable(row_end) && $stable(col_begin) &&
		$stable(col_end) && $stable(last_rect))
		else $error("stalled result changed");

endmodule

bind rect_bisection_partitioner rbp_checker u_rbp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.rect_index (rsp.rect_index),
	.row_begin  (rsp.row_begin),
	.row_end    (rsp.row_end),
	.col_begin  (rsp.col_begin),
	.col_end    (rsp.col_end),
	.last_rect  (rsp.last_rect)
);
